[sv/b64cd_pkg.sv]
// ----------------------------------------------------------------------------
// b64cd_pkg
// Shared types, constants and the alphabet lookup of the Base64 credential
// decoder.
// ----------------------------------------------------------------------------
package b64cd_pkg;

	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_SEP = 8'h3A;
	localparam int unsigned MAX_BYTES = 3;

	typedef struct packed {
		logic [7:0] decoded_byte;
		logic       byte_present;
		logic       is_separator;
		logic       end_of_run;
		logic       length_error;
	} result_t;

	// up to three results produced by one character
	typedef struct packed {
		logic [1:0]                    count;
		result_t [MAX_BYTES-1:0]       res;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic pend;
	} buf_stat_t;

	// bit 6 set marks a character outside the alphabet
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd52;
		end else if (c == 8'h2B) begin
			d = 8'd62;
		end else if (c == 8'h2F) begin
			d = 8'd63;
		end else begin
			d = 8'd64;
		end
		return d[6:0];
	endfunction

endpackage

[sv/b64cd_char_if.sv]
// ----------------------------------------------------------------------------
// b64cd_char_if
// Character channel: one encoded character per word.
// ----------------------------------------------------------------------------
interface b64cd_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       final_char;

	modport source (output valid, output text_char, output final_char, input ready);
	modport sink   (input valid, input text_char, input final_char, output ready);
endinterface

[sv/b64cd_byte_if.sv]
// ----------------------------------------------------------------------------
// b64cd_byte_if
// Result channel: one decoded byte with its flags per word.
// ----------------------------------------------------------------------------
interface b64cd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] decoded_byte;
	logic       byte_present;
	logic       is_separator;
	logic       end_of_run;
	logic       length_error;

	modport source (output valid, output decoded_byte, output byte_present,
		output is_separator, output end_of_run, output length_error, input ready);
	modport sink   (input valid, input decoded_byte, input byte_present,
		input is_separator, input end_of_run, input length_error, output ready);
endinterface

[sv/b64cd_decode.sv]
// ----------------------------------------------------------------------------
// b64cd_decode
// Group state and single-pass decode of one character into up to three
// result words.
// ----------------------------------------------------------------------------
module b64cd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          text_char,
	input  logic                final_char,
	output b64cd_pkg::bundle_t  bundle
);

	logic [1:0]  pos_q;
	logic [17:0] acc_q;
	logic        stop_q;
	logic        split_q;
	logic [1:0]  cnt_q;

	logic [1:0]  pos_d;
	logic [17:0] acc_d;
	logic        stop_d;
	logic        split_d;
	logic [1:0]  cnt_d;

	always_comb begin
		logic        crlf;
		logic [6:0]  s;
		logic        bad;
		logic [5:0]  v;
		logic [5:0]  a;
		logic [5:0]  b;
		logic [5:0]  cc;
		logic [7:0]  bytes [3];
		logic [1:0]  nb;
		logic [1:0]  n;
		logic        sf;
		crlf   = (text_char == b64cd_pkg::CH_CR) || (text_char == b64cd_pkg::CH_LF);
		s      = b64cd_pkg::sextet_of(text_char);
		bad    = s[6];
		v      = bad ? 6'd0 : s[5:0];
		a      = acc_q[17:12];
		b      = acc_q[11:6];
		cc     = acc_q[5:0];
		bytes[0] = 8'd0;
		bytes[1] = 8'd0;
		bytes[2] = 8'd0;
		nb     = 2'd0;
		pos_d  = pos_q;
		acc_d  = acc_q;
		stop_d = stop_q;
		cnt_d  = crlf ? cnt_q : cnt_q + 2'd1;

		if (!crlf && !stop_q) begin
			case (pos_q)
				2'd0: begin
					acc_d = {12'd0, v};
					pos_d = 2'd1;
				end
				2'd1: begin
					if (bad) begin
						bytes[0] = {cc, 2'b00};
						nb       = 2'd1;
						stop_d   = 1'b1;
					end else begin
						acc_d = {acc_q[11:0], v};
						pos_d = 2'd2;
					end
				end
				2'd2: begin
					if (bad) begin
						bytes[0] = {b, cc[5:4]};
						nb       = 2'd1;
						stop_d   = 1'b1;
					end else begin
						acc_d = {acc_q[11:0], v};
						pos_d = 2'd3;
					end
				end
				default: begin
					bytes[0] = {a, b[5:4]};
					bytes[1] = {b[3:0], cc[5:2]};
					bytes[2] = {cc[1:0], v};
					nb       = bad ? 2'd2 : 2'd3;
					stop_d   = stop_q | bad;
					acc_d    = 18'd0;
					pos_d    = 2'd0;
				end
			endcase
		end

		// first colon wins unless a zero byte shows up before it
		sf = split_q;
		for (int i = 0; i < b64cd_pkg::MAX_BYTES; i++) begin
			bundle.res[i].decoded_byte = bytes[i];
			bundle.res[i].byte_present = (2'(i) < nb);
			bundle.res[i].is_separator = 1'b0;
			bundle.res[i].end_of_run   = 1'b0;
			bundle.res[i].length_error = 1'b0;
			if ((2'(i) < nb) && !sf) begin
				if (bytes[i] == b64cd_pkg::CH_SEP) begin
					bundle.res[i].is_separator = 1'b1;
					sf = 1'b1;
				end else if (bytes[i] == 8'd0) begin
					sf = 1'b1;
				end
			end
		end
		split_d = sf;

		n = nb;
		if (final_char) begin
			if (nb == 2'd0) begin
				n = 2'd1;
			end
			for (int i = 0; i < b64cd_pkg::MAX_BYTES; i++) begin
				if (2'(i) == n - 2'd1) begin
					bundle.res[i].end_of_run   = 1'b1;
					bundle.res[i].length_error = (cnt_d != 2'd0);
				end
			end
			pos_d   = 2'd0;
			acc_d   = 18'd0;
			stop_d  = 1'b0;
			split_d = 1'b0;
			cnt_d   = 2'd0;
		end
		bundle.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 2'd0;
			acc_q   <= 18'd0;
			stop_q  <= 1'b0;
			split_q <= 1'b0;
			cnt_q   <= 2'd0;
		end else if (accept) begin
			pos_q   <= pos_d;
			acc_q   <= acc_d;
			stop_q  <= stop_d;
			split_q <= split_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

[sv/b64cd_outbuf.sv]
// ----------------------------------------------------------------------------
// b64cd_outbuf
// Result register holding the words of one character, drained one word per
// handshake, with a second register taking the next character's words while
// the first one drains.
// ----------------------------------------------------------------------------
module b64cd_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  b64cd_pkg::bundle_t    bundle,
	output logic                  can_load,
	output b64cd_pkg::buf_stat_t  stat,
	b64cd_byte_if.source          byte_ch
);

	b64cd_pkg::bundle_t bundle_s1;
	b64cd_pkg::bundle_t pend_q;
	logic [1:0]         idx_q;
	logic               full_q;
	logic               pend_full_q;
	logic               last;
	logic               done;
	logic               drain_free;
	b64cd_pkg::result_t cur;

	assign last       = (idx_q == bundle_s1.count - 2'd1);
	assign done       = full_q && last && byte_ch.ready;
	assign drain_free = !full_q || done;
	assign can_load   = !pend_full_q;
	assign stat       = '{full: full_q, pend: pend_full_q};
	assign cur        = bundle_s1.res[idx_q];

	assign byte_ch.valid        = full_q;
	assign byte_ch.decoded_byte = cur.decoded_byte;
	assign byte_ch.byte_present = cur.byte_present;
	assign byte_ch.is_separator = cur.is_separator;
	assign byte_ch.end_of_run   = cur.end_of_run;
	assign byte_ch.length_error = cur.length_error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			full_q      <= 1'b0;
			pend_full_q <= 1'b0;
		end else if (load && drain_free) begin
			idx_q  <= 2'd0;
			full_q <= 1'b1;
		end else if (load) begin
			// drain still busy: park the new words
			pend_full_q <= 1'b1;
			if (full_q && byte_ch.ready) begin
				idx_q <= idx_q + 2'd1;
			end
		end else if (done) begin
			idx_q       <= 2'd0;
			full_q      <= pend_full_q;
			pend_full_q <= 1'b0;
		end else if (full_q && byte_ch.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && drain_free) begin
			bundle_s1 <= bundle;
		end else if (done && pend_full_q) begin
			bundle_s1 <= pend_q;
		end
		if (load && !drain_free) begin
			pend_q <= bundle;
		end
	end

endmodule

[sv/base64_credential_decoder_core.sv]
// Result words are registered; the second register holds them while the first drains.
// Throughput: one character per cycle sustained; a completed group drains three words
// while the next characters of the following group are taken.
// Input waits only while the second result register is occupied, e.g. a closing word
// right behind a completed group stalls until that group drains, or under output back-pressure.
// Reset: arst_n clears group state and empties both result registers; no clearing pass.
// ----------------------------------------------------------------------------
// base64_credential_decoder_core
// Base64 credential decoder: characters in, decoded bytes out, with the
// username/password separator and a closing word per credential.
// ----------------------------------------------------------------------------
module base64_credential_decoder_core (
	input  logic          clk,
	input  logic          arst_n,
	b64cd_char_if.sink    char_ch,
	b64cd_byte_if.source  byte_ch
);

	b64cd_pkg::bundle_t   bundle;
	b64cd_pkg::buf_stat_t stat;
	logic                 can_load;
	logic                 accept;

	assign char_ch.ready = can_load;
	assign accept        = char_ch.valid && can_load;

	b64cd_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.text_char  (char_ch.text_char),
		.final_char (char_ch.final_char),
		.bundle     (bundle)
	);

	b64cd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && (bundle.count != 2'd0)),
		.bundle    (bundle),
		.can_load  (can_load),
		.stat      (stat),
		.byte_ch   (byte_ch)
	);

	// a final character always produces a closing word
	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && char_ch.final_char) |=> byte_ch.valid)
		else $error("no result after final character");

	// no new character while the second result register is occupied
	a_hold_when_pending: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pend |-> !char_ch.ready)
		else $error("input taken with words pending");

	// an empty word is only ever the closing word
	a_empty_is_closing: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_ch.valid && !byte_ch.byte_present) |-> byte_ch.end_of_run)
		else $error("empty word without end of run");

	// length error only rides on the closing word
	a_error_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_ch.valid && byte_ch.length_error) |-> byte_ch.end_of_run)
		else $error("length error off the closing word");

endmodule

[tb/tb_base64_credential_decoder_core.sv]
// ----------------------------------------------------------------------------
// tb_base64_credential_decoder_core
// Feeds Base64 credential text into the decoder core one character per word
// and checks every decoded byte, separator flag and closing word against the
// typed words of a directed row or else an in-bench decoder. A short table of
// directed characters comes first, then random credentials, broken text and
// noise under changing amounts of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_base64_credential_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_CHARS   = 320;

	// one row of the directed table; typed_n < 0 means the decoder model predicts
	typedef struct {
		logic [7:0]          ch;
		bit                  fin;
		int                  typed_n;
		b64cd_pkg::result_t  w [3];
	} char_row_t;

	logic clk;
	logic arst_n;

	b64cd_char_if char_ch ();
	b64cd_byte_if byte_ch ();

	base64_credential_decoder_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_ch),
		.byte_ch (byte_ch)
	);

	// decoder model state
	logic [1:0]  grp_pos    = '0;
	logic [17:0] sextets    = '0;
	bit          halted     = 1'b0;
	bit          split_seen = 1'b0;
	logic [1:0]  char_count = '0;

	b64cd_pkg::result_t expected_bytes [$];
	char_row_t          stim_table [$];
	int unsigned        mismatch_count = 0;
	int unsigned        sent_count     = 0;
	int unsigned        src_idle_pct   = 0;
	int unsigned        sink_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [6:0] alphabet_index(input logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return {1'b0, 6'(c - "A")};
		end
		if (c >= "a" && c <= "z") begin
			return {1'b0, 6'(c - "a" + 8'd26)};
		end
		if (c >= "0" && c <= "9") begin
			return {1'b0, 6'(c - "0" + 8'd52)};
		end
		if (c == "+") begin
			return 7'd62;
		end
		if (c == "/") begin
			return 7'd63;
		end
		return 7'h40;
	endfunction

	function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
		if (idx < 6'd26) begin
			return "A" + {2'b00, idx};
		end
		if (idx < 6'd52) begin
			return "a" + {2'b00, idx} - 8'd26;
		end
		if (idx < 6'd62) begin
			return "0" + {2'b00, idx} - 8'd52;
		end
		return (idx == 6'd62) ? "+" : "/";
	endfunction

	function automatic b64cd_pkg::result_t mk_word(input logic [7:0] b, input bit present,
		input bit sep, input bit eor, input bit lerr);
		return {b, present, sep, eor, lerr};
	endfunction

	function automatic b64cd_pkg::result_t emit_byte(input logic [7:0] b);
		b64cd_pkg::result_t r;
		r = '0;
		r.decoded_byte = b;
		r.byte_present = 1'b1;
		// a zero byte before the first colon rules out any separator
		if (!split_seen) begin
			if (b == b64cd_pkg::CH_SEP) begin
				r.is_separator = 1'b1;
				split_seen = 1'b1;
			end else if (b == 8'h00) begin
				split_seen = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic int decode_char(input logic [7:0] c, input bit fin,
		output b64cd_pkg::result_t w [3]);
		logic [6:0] idx;
		logic [5:0] v;
		logic [5:0] hi;
		logic [5:0] mid;
		logic [5:0] lo;
		bit         bad;
		int         n;
		n = 0;
		for (int i = 0; i < 3; i++) begin
			w[i] = '0;
		end
		if (c != b64cd_pkg::CH_CR && c != b64cd_pkg::CH_LF) begin
			char_count = char_count + 2'd1;
			if (!halted) begin
				idx = alphabet_index(c);
				bad = idx[6];
				v   = bad ? 6'd0 : idx[5:0];
				hi  = sextets[17:12];
				mid = sextets[11:6];
				lo  = sextets[5:0];
				case (grp_pos)
					2'd0: begin
						sextets = {12'd0, v};
						grp_pos = 2'd1;
					end
					2'd1: begin
						if (bad) begin
							w[0] = emit_byte({lo, 2'b00});
							n = 1;
							halted = 1'b1;
						end else begin
							sextets = {sextets[11:0], v};
							grp_pos = 2'd2;
						end
					end
					2'd2: begin
						if (bad) begin
							w[0] = emit_byte({mid, lo[5:4]});
							n = 1;
							halted = 1'b1;
						end else begin
							sextets = {sextets[11:0], v};
							grp_pos = 2'd3;
						end
					end
					default: begin
						w[0] = emit_byte({hi, mid[5:4]});
						w[1] = emit_byte({mid[3:0], lo[5:2]});
						n = 2;
						if (bad) begin
							halted = 1'b1;
						end else begin
							w[2] = emit_byte({lo[1:0], v});
							n = 3;
						end
						sextets = '0;
						grp_pos = 2'd0;
					end
				endcase
			end
		end
		if (fin) begin
			// no byte from the last character: an empty closing word carries the flags
			if (n == 0) begin
				n = 1;
			end
			w[n-1].end_of_run   = 1'b1;
			w[n-1].length_error = (char_count != 2'd0);
			grp_pos    = '0;
			sextets    = '0;
			halted     = 1'b0;
			split_seen = 1'b0;
			char_count = '0;
		end
		return n;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		if (mismatch_count < 40) begin
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		end
		mismatch_count++;
	endtask

	task automatic add_row(input logic [7:0] c, input bit fin, input int typed_n = -1,
		input b64cd_pkg::result_t w0 = '0, input b64cd_pkg::result_t w1 = '0,
		input b64cd_pkg::result_t w2 = '0);
		char_row_t r;
		r.ch      = c;
		r.fin     = fin;
		r.typed_n = typed_n;
		r.w[0]    = w0;
		r.w[1]    = w1;
		r.w[2]    = w2;
		stim_table.push_back(r);
	endtask

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_char(input char_row_t r);
		b64cd_pkg::result_t w [3];
		int                 n;
		while ($urandom_range(99) < src_idle_pct) begin
			char_ch.valid = 1'b0;
			@(negedge clk);
		end
		char_ch.valid      = 1'b1;
		char_ch.text_char  = r.ch;
		char_ch.final_char = r.fin;
		do @(posedge clk); while (char_ch.ready !== 1'b1);
		n = decode_char(r.ch, r.fin, w);
		if (r.typed_n >= 0) begin
			n = r.typed_n;
			w = r.w;
		end
		for (int i = 0; i < n; i++) begin
			expected_bytes.push_back(w[i]);
		end
		sent_count++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] rand_raw_byte();
		if ($urandom_range(15) == 0) begin
			return 8'($urandom_range(255));
		end
		return 8'($urandom_range(126, 32));
	endfunction

	task automatic send_credential();
		logic [7:0]  raw [$];
		logic [7:0]  txt [$];
		logic [23:0] grp;
		int          left;
		int unsigned kind;
		bit          with_fin;
		char_row_t   r;
		kind     = $urandom_range(99);
		with_fin = 1'b1;
		if (kind < 85) begin
			repeat ($urandom_range(6)) raw.push_back(rand_raw_byte());
			if ($urandom_range(9) != 0) begin
				raw.push_back(b64cd_pkg::CH_SEP);
			end
			repeat ($urandom_range(8)) raw.push_back(rand_raw_byte());
			for (int i = 0; i < raw.size(); i += 3) begin
				left = raw.size() - i;
				grp = {raw[i], (left > 1) ? raw[i+1] : 8'h00, (left > 2) ? raw[i+2] : 8'h00};
				txt.push_back(b64_symbol(grp[23:18]));
				txt.push_back(b64_symbol(grp[17:12]));
				txt.push_back((left > 1) ? b64_symbol(grp[11:6]) : "=");
				txt.push_back((left > 2) ? b64_symbol(grp[5:0]) : "=");
			end
			// damaged text: missing padding, cut short, or a stray byte
			if (kind >= 65) begin
				case ($urandom_range(2))
					0: begin
						while (txt.size() > 0 && txt[txt.size()-1] == "=") txt.pop_back();
					end
					1: begin
						if (txt.size() > 1) begin
							repeat ($urandom_range(txt.size() - 1, 1)) txt.pop_back();
						end
					end
					default: begin
						if (txt.size() > 0) begin
							txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
						end
					end
				endcase
			end
			if ($urandom_range(9) < 3) begin
				repeat ($urandom_range(2, 1)) begin
					txt.insert($urandom_range(txt.size()),
						$urandom_range(1) ? b64cd_pkg::CH_CR : b64cd_pkg::CH_LF);
				end
			end
			if ($urandom_range(99) < 15) begin
				txt.push_back($urandom_range(1) ? b64cd_pkg::CH_CR : b64cd_pkg::CH_LF);
			end
		end else begin
			repeat ($urandom_range(10, 1)) txt.push_back(8'($urandom_range(255)));
			with_fin = ($urandom_range(99) < 80);
		end
		if (txt.size() == 0) begin
			txt.push_back(b64cd_pkg::CH_LF);
		end
		r.typed_n = -1;
		for (int i = 0; i < txt.size(); i++) begin
			r.ch  = txt[i];
			r.fin = with_fin && (i == txt.size() - 1);
			send_char(r);
		end
	endtask

	initial begin
		byte_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			byte_ch.ready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		b64cd_pkg::result_t want;
		if (arst_n && byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("word with nothing expected", byte_ch.decoded_byte, 8'h00);
			end else begin
				want = expected_bytes.pop_front();
				if (byte_ch.decoded_byte !== want.decoded_byte) begin
					report_mismatch("decoded_byte", byte_ch.decoded_byte, want.decoded_byte);
				end
				if (byte_ch.byte_present !== want.byte_present) begin
					report_mismatch("byte_present", 8'(byte_ch.byte_present),
						8'(want.byte_present));
				end
				if (byte_ch.is_separator !== want.is_separator) begin
					report_mismatch("is_separator", 8'(byte_ch.is_separator),
						8'(want.is_separator));
				end
				if (byte_ch.end_of_run !== want.end_of_run) begin
					report_mismatch("end_of_run", 8'(byte_ch.end_of_run),
						8'(want.end_of_run));
				end
				if (byte_ch.length_error !== want.length_error) begin
					report_mismatch("length_error", 8'(byte_ch.length_error),
						8'(want.length_error));
				end
			end
		end
	end

	// ends the run when no word moves on either side for too long
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((char_ch.valid === 1'b1 && char_ch.ready === 1'b1) ||
				(byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("watchdog: no word moved for %0d cycles, %0d words still expected",
			WATCHDOG_LIMIT, expected_bytes.size());
		$display("tb_base64_credential_decoder_core: done, errors");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		char_ch.valid      = 1'b0;
		char_ch.text_char  = 8'h00;
		char_ch.final_char = 1'b0;

		// padding after two characters leaves a lone colon, the separator
		add_row("O", 1'b0, 0);
		add_row("g", 1'b0, 0);
		add_row("=", 1'b0, 1, mk_word(8'h3A, 1'b1, 1'b1, 1'b0, 1'b0));
		add_row("=", 1'b1, 1, mk_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
		// all-ones sextets
		add_row("/", 1'b0, 0);
		add_row("/", 1'b0, 0);
		add_row("/", 1'b0, 0);
		add_row("/", 1'b1, 3, mk_word(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0),
			mk_word(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0), mk_word(8'hFF, 1'b1, 1'b0, 1'b1, 1'b0));
		// zero bytes come first, so the colons after them are plain data
		add_row("A", 1'b0);
		add_row("A", 1'b0);
		add_row(b64cd_pkg::CH_CR, 1'b0);
		add_row("A", 1'b0);
		add_row("A", 1'b0);
		add_row("O", 1'b0);
		add_row("j", 1'b0);
		add_row("o", 1'b0);
		add_row("6", 1'b0);
		add_row(b64cd_pkg::CH_LF, 1'b1);
		// bad second character forces one byte out, three characters is a length error
		add_row("Q", 1'b0, 0);
		add_row(8'hFF, 1'b0, 1, mk_word(8'h40, 1'b1, 1'b0, 1'b0, 1'b0));
		add_row(8'h00, 1'b1, 1, mk_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
		// padding in fourth place on the final character gives two bytes
		add_row("Y", 1'b0);
		add_row("W", 1'b0);
		add_row("I", 1'b0);
		add_row("=", 1'b1);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_table[i]) begin
			send_char(stim_table[i]);
		end

		sent_count = 0;
		while (sent_count < RANDOM_CHARS) begin
			case (sent_count / (RANDOM_CHARS / 4))
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 48;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 48;
				end
				default: begin
					src_idle_pct   = 9;
					sink_stall_pct = 9;
				end
			endcase
			send_credential();
		end
		char_ch.valid = 1'b0;

		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_base64_credential_decoder_core: done, clean");
		end else begin
			$display("tb_base64_credential_decoder_core: done, errors");
		end
		$finish;
	end

endmodule

[sim.f]
sv/b64cd_pkg.sv
sv/b64cd_char_if.sv
sv/b64cd_byte_if.sv
sv/b64cd_decode.sv
sv/b64cd_outbuf.sv
sv/base64_credential_decoder_core.sv
tb/tb_base64_credential_decoder_core.sv
